[sv/lpc_pkg.sv]
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and constants of the layered pixel compositor.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // default frame geometry and layer precision
  localparam int WIDTH_MAX_DEF  = 256;
  localparam int HEIGHT_MAX_DEF = 256;
  localparam int LAYER_BITS_DEF = 8;

  // fixed field widths
  localparam int COLOR_W     = 32;
  localparam int POS_W       = 8;
  localparam int LAYER_IN_W  = 8;
  localparam int WIN_W       = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int SAT_W       = 13;

  // clear generation tag kept with every pixel
  localparam int EPOCH_BITS = 4;
  localparam logic [EPOCH_BITS-1:0] EPOCH_EMPTY = '0;
  localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
  localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HEIGHT = CFG_INDEX_W'(1);

  typedef enum logic {
    MODE_SWEEP = 1'b0,
    MODE_RUN   = 1'b1
  } mode_t;

endpackage

[sv/lpc_frame_ram.sv]
// ----------------------------------------------------------------------------
// lpc_frame_ram
// Single-port-write, single-port-read frame memory, registered read data.
// ----------------------------------------------------------------------------
module lpc_frame_ram #(
  parameter int DEPTH  = 65536,
  parameter int DATA_W = 44,
  parameter int ADDR_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[sv/layered_pixel_compositor.sv]
// ----------------------------------------------------------------------------
// layered_pixel_compositor
// Framebuffer with a per-pixel layer test, window clipping and fast clear.
// ----------------------------------------------------------------------------
// An item (op, pos_x, pos_y, layer, color) is taken on a clock edge with
// start high and busy low. Draws, reads and clears may follow each other in
// consecutive cycles: one item per cycle while busy stays low. Each item
// gives exactly one result beat: done is registered from stage_valid, which
// is registered at the accepting edge, and is high for one cycle, with
// read_color, read_hit and draw_taken. The receiver cannot stall.
// Colour, layer and a clear generation tag live in one frame memory with a
// registered read; a draw reads at acceptance and writes back in the next
// cycle, and a write-back is forwarded to an item that read the same pixel
// in that cycle. A clear just advances the generation tag. After reset, and
// on every clear that wraps the tag (every 2**EPOCH_BITS-1 clears), a
// clearing pass writes every pixel once, with busy held high throughout;
// a wrapping clear also holds busy high in the cycle before its pass.
// Window registers are written through cfg_write/cfg_index/cfg_data at any
// time, also during the pass.
// ----------------------------------------------------------------------------
module layered_pixel_compositor #(
  parameter int WIDTH_MAX  = lpc_pkg::WIDTH_MAX_DEF,
  parameter int HEIGHT_MAX = lpc_pkg::HEIGHT_MAX_DEF,
  parameter int LAYER_BITS = lpc_pkg::LAYER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      op,
  input  logic [lpc_pkg::POS_W-1:0]       pos_x,
  input  logic [lpc_pkg::POS_W-1:0]       pos_y,
  input  logic [lpc_pkg::LAYER_IN_W-1:0]  layer,
  input  logic [lpc_pkg::COLOR_W-1:0]     color,
  input  logic                            cfg_write,
  input  logic [lpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lpc_pkg::WIN_W-1:0]       cfg_data,
  output logic                            done,
  output logic [lpc_pkg::COLOR_W-1:0]     read_color,
  output logic                            read_hit,
  output logic                            draw_taken
);

  import lpc_pkg::*;

  localparam int PIXELS = WIDTH_MAX * HEIGHT_MAX;
  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int WORD_W = EPOCH_BITS + LAYER_BITS + COLOR_W;
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(PIXELS - 1);
  localparam logic [WIN_W-1:0] WIN_W_RESET =
    WIN_W'((WIDTH_MAX < 256) ? WIDTH_MAX : 256);
  localparam logic [WIN_W-1:0] WIN_H_RESET =
    WIN_W'((HEIGHT_MAX < 256) ? HEIGHT_MAX : 256);

  // window registers
  logic [WIN_W-1:0] window_width;
  logic [WIN_W-1:0] window_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= WIN_W_RESET;
      window_height <= WIN_H_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_WIDTH: begin
          window_width <= (SAT_W'(cfg_data) > SAT_W'(WIDTH_MAX)) ?
                          WIN_W'(WIDTH_MAX) : cfg_data;
        end
        REG_WINDOW_HEIGHT: begin
          window_height <= (SAT_W'(cfg_data) > SAT_W'(HEIGHT_MAX)) ?
                           WIN_W'(HEIGHT_MAX) : cfg_data;
        end
        default: ;
      endcase
    end
  end

  // control state
  mode_t                 mode;
  mode_t                 mode_next;
  logic [ADDR_W-1:0]     sweep_addr;
  logic [EPOCH_BITS-1:0] epoch;
  logic                  accept;
  logic                  wrap_pending;

  // item in the compare stage
  logic                  stage_valid;
  op_t                   stage_op;
  logic [ADDR_W-1:0]     stage_addr;
  logic                  stage_inwin;
  logic [LAYER_BITS-1:0] stage_layer;
  logic [COLOR_W-1:0]    stage_color;

  // memory ports and forwarding
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  logic [WORD_W-1:0] fwd_data;

  // decoded stage results
  logic [WORD_W-1:0]     entry;
  logic [EPOCH_BITS-1:0] entry_epoch;
  logic [LAYER_BITS-1:0] entry_layer;
  logic [COLOR_W-1:0]    entry_color;
  logic                  entry_drawn;
  logic                  take;
  logic                  hit;

  // input address, only meaningful inside the window
  logic [31:0] pixel_index;
  logic        in_window;

  assign pixel_index = 32'(pos_y) * 32'(WIDTH_MAX) + 32'(pos_x);
  assign mem_raddr   = pixel_index[ADDR_W-1:0];
  assign in_window   = ({1'b0, pos_x} < window_width) &&
                       ({1'b0, pos_y} < window_height);

  assign wrap_pending = stage_valid && (stage_op == OP_CLEAR) && (epoch == EPOCH_LAST);
  assign accept       = start && !busy;

  // mode, next state
  always_comb begin
    mode_next = mode;
    unique case (mode)
      MODE_SWEEP: begin
        if (sweep_addr == ADDR_LAST) begin
          mode_next = MODE_RUN;
        end
      end
      MODE_RUN: begin
        if (wrap_pending) begin
          mode_next = MODE_SWEEP;
        end
      end
      default: mode_next = MODE_SWEEP;
    endcase
  end

  // mode, outputs
  always_comb begin
    busy      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = stage_addr;
    mem_wdata = {epoch, stage_layer, stage_color};
    unique case (mode)
      MODE_SWEEP: begin
        busy      = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = sweep_addr;
        mem_wdata = {EPOCH_EMPTY, {(WORD_W - EPOCH_BITS){1'b0}}};
      end
      MODE_RUN: begin
        busy   = wrap_pending;
        mem_we = take;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_SWEEP;
      sweep_addr <= '0;
      epoch      <= EPOCH_FIRST;
    end else begin
      mode <= mode_next;
      if (mode == MODE_SWEEP) begin
        sweep_addr <= (sweep_addr == ADDR_LAST) ? '0 : sweep_addr + ADDR_W'(1);
      end
      if (stage_valid && (stage_op == OP_CLEAR)) begin
        epoch <= (epoch == EPOCH_LAST) ? EPOCH_FIRST : epoch + EPOCH_BITS'(1);
      end
    end
  end

  // accept stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_op    <= op_t'(op);
      stage_addr  <= mem_raddr;
      stage_inwin <= in_window;
      stage_layer <= LAYER_BITS'(layer);
      stage_color <= color;
    end
  end

  lpc_frame_ram #(
    .DEPTH  (PIXELS),
    .DATA_W (WORD_W),
    .ADDR_W (ADDR_W)
  ) u_frame_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // last write-back, for an item that read the same pixel on that edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= mem_we;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= mem_waddr;
    fwd_data <= mem_wdata;
  end

  // compare stage
  assign entry       = (fwd_valid && (fwd_addr == stage_addr)) ? fwd_data : mem_rdata;
  assign entry_epoch = entry[WORD_W-1 -: EPOCH_BITS];
  assign entry_layer = entry[COLOR_W +: LAYER_BITS];
  assign entry_color = entry[COLOR_W-1:0];
  assign entry_drawn = (entry_epoch == epoch);

  // later write wins a tie
  assign take = stage_valid && (stage_op == OP_DRAW) && stage_inwin &&
                (!entry_drawn || (stage_layer <= entry_layer));
  assign hit  = stage_valid && (stage_op == OP_READ) && stage_inwin && entry_drawn;

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    read_color <= hit ? entry_color : '0;
    read_hit   <= hit;
    draw_taken <= take;
  end

endmodule

[bench/lpc_checker.sv]
// ----------------------------------------------------------------------------
// lpc_checker
// Result predictor and scoreboard for the layered pixel compositor.
// ----------------------------------------------------------------------------
// Watches the command, window register and result ports. Every accepted
// command is run through a private framebuffer model and the expected result
// beat is queued; every done beat is compared field by field with the oldest
// entry. Clears are modelled with a generation count per pixel.
// ----------------------------------------------------------------------------
module lpc_checker #(
  parameter int WIDTH_MAX  = lpc_pkg::WIDTH_MAX_DEF,
  parameter int HEIGHT_MAX = lpc_pkg::HEIGHT_MAX_DEF,
  parameter int LAYER_BITS = lpc_pkg::LAYER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [1:0]                      op,
  input  logic [lpc_pkg::POS_W-1:0]       pos_x,
  input  logic [lpc_pkg::POS_W-1:0]       pos_y,
  input  logic [lpc_pkg::LAYER_IN_W-1:0]  layer,
  input  logic [lpc_pkg::COLOR_W-1:0]     color,
  input  logic                            cfg_write,
  input  logic [lpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lpc_pkg::WIN_W-1:0]       cfg_data,
  input  logic                            done,
  input  logic [lpc_pkg::COLOR_W-1:0]     read_color,
  input  logic                            read_hit,
  input  logic                            draw_taken,
  output int                              fail_count,
  output int                              outstanding,
  output int                              beats_checked,
  output int                              draws_stored,
  output int                              read_hits
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpc_pkg::*;

  localparam int PIXELS = WIDTH_MAX * HEIGHT_MAX;
  localparam int unsigned LAYER_MASK = (1 << LAYER_BITS) - 1;
  localparam int unsigned WIN_W_RESET = (256 > WIDTH_MAX) ? WIDTH_MAX : 256;
  localparam int unsigned WIN_H_RESET = (256 > HEIGHT_MAX) ? HEIGHT_MAX : 256;

  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic               read_hit;
    logic               draw_taken;
  } pixel_beat_t;

  pixel_beat_t expected_beats [$];

  logic [COLOR_W-1:0] frame_color [PIXELS];
  int unsigned        frame_layer [PIXELS];
  int unsigned        frame_gen   [PIXELS];
  int unsigned        clear_gen = 1;
  int unsigned        win_w = WIN_W_RESET;
  int unsigned        win_h = WIN_H_RESET;

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    beats_checked = 0;
    draws_stored  = 0;
    read_hits     = 0;
  end

  // a pixel counts as drawn only when its generation matches the current one
  function automatic pixel_beat_t run_command(logic [1:0] kind, logic [POS_W-1:0] x,
                                              logic [POS_W-1:0] y,
                                              logic [LAYER_IN_W-1:0] lay_in,
                                              logic [COLOR_W-1:0] col);
    pixel_beat_t beat;
    int unsigned idx;
    int unsigned lay;
    bit          visible;
    beat    = '0;
    lay     = int'(lay_in) & LAYER_MASK;
    idx     = int'(y) * WIDTH_MAX + int'(x);
    visible = (x < win_w) && (y < win_h) && (idx < PIXELS);
    case (kind)
      OP_DRAW: begin
        if (visible && (frame_gen[idx] != clear_gen || lay <= frame_layer[idx])) begin
          frame_color[idx] = col;
          frame_layer[idx] = lay;
          frame_gen[idx]   = clear_gen;
          beat.draw_taken  = 1'b1;
        end
      end
      OP_CLEAR: clear_gen++;
      OP_READ: begin
        if (visible && frame_gen[idx] == clear_gen) begin
          beat.read_color = frame_color[idx];
          beat.read_hit   = 1'b1;
        end
      end
      default: ;
    endcase
    return beat;
  endfunction

  always @(posedge clk) begin
    pixel_beat_t want;
    pixel_beat_t got;
    if (rst) begin
      clear_gen++;
      win_w = WIN_W_RESET;
      win_h = WIN_H_RESET;
      expected_beats.delete();
    end else begin
      if (done === 1'b1) begin
        beats_checked++;
        if (expected_beats.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          got  = '{read_color, read_hit, draw_taken};
          if (got.read_color !== want.read_color) begin
            $error("read_color: expected %h, actual %h", want.read_color, got.read_color);
            fail_count++;
          end
          if (got.read_hit !== want.read_hit) begin
            $error("read_hit: expected %b, actual %b", want.read_hit, got.read_hit);
            fail_count++;
          end
          if (got.draw_taken !== want.draw_taken) begin
            $error("draw_taken: expected %b, actual %b", want.draw_taken, got.draw_taken);
            fail_count++;
          end
        end
      end else if (done !== 1'b0) begin
        $error("done: expected 0 or 1, actual %b", done);
        fail_count++;
      end

      // a command taken on this edge still sees the old window
      if (start === 1'b1 && busy === 1'b0) begin
        want = run_command(op, pos_x, pos_y, layer, color);
        expected_beats.push_back(want);
        draws_stored += want.draw_taken;
        read_hits    += want.read_hit;
      end

      if (cfg_write === 1'b1) begin
        case (cfg_index)
          REG_WINDOW_WIDTH:  win_w = (int'(cfg_data) > WIDTH_MAX) ? WIDTH_MAX : int'(cfg_data);
          REG_WINDOW_HEIGHT: win_h = (int'(cfg_data) > HEIGHT_MAX) ? HEIGHT_MAX : int'(cfg_data);
          default: ;
        endcase
      end
    end
    outstanding = expected_beats.size();
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Command stimulus and verdict for the layered pixel compositor.
// ----------------------------------------------------------------------------
// A short directed sequence under the reset window, then random draw, read,
// clear and no-op commands over a set of window sizes from zero to
// saturated, with bursty and gappy streams. The checker beside the block
// predicts and compares every result beat and reports its failure count here.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int NUM_PHASES     = 6;
  localparam int HOT_PIXELS     = 12;
  localparam int BURST_RUN      = 24;

  // indexes past the register list, writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             op = OP_NONE;
  logic [POS_W-1:0]       pos_x = '0;
  logic [POS_W-1:0]       pos_y = '0;
  logic [LAYER_IN_W-1:0]  layer = '0;
  logic [COLOR_W-1:0]     color = '0;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_WINDOW_WIDTH;
  logic [WIN_W-1:0]       cfg_data = '0;
  logic                   done;
  logic [COLOR_W-1:0]     read_color;
  logic                   read_hit;
  logic                   draw_taken;

  int fail_count;
  int outstanding;
  int beats_checked;
  int draws_stored;
  int read_hits;

  int idle_cycles   = 0;
  int commands_sent = 0;
  int clears_sent   = 0;
  int cur_w         = 256;
  int cur_h         = 256;
  bit burst         = 1'b0;

  int win_w_plan [NUM_PHASES] = '{0, 511, 1, 37, 256, 200};
  int win_h_plan [NUM_PHASES] = '{0, 511, 1, 180, 3, 256};
  int item_plan  [NUM_PHASES] = '{60, 220, 120, 260, 250, 270};

  int hot_x [HOT_PIXELS];
  int hot_y [HOT_PIXELS];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  layered_pixel_compositor i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .layer      (layer),
    .color      (color),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .read_color (read_color),
    .read_hit   (read_hit),
    .draw_taken (draw_taken)
  );

  lpc_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .layer         (layer),
    .color         (color),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .read_color    (read_color),
    .read_hit      (read_hit),
    .draw_taken    (draw_taken),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .beats_checked (beats_checked),
    .draws_stored  (draws_stored),
    .read_hits     (read_hits)
  );

  // start stays high on return so back-to-back commands need no extra edge
  task automatic issue(op_t kind, int x, int y, int lay, logic [COLOR_W-1:0] col);
    start <= 1'b1;
    op    <= kind;
    pos_x <= POS_W'(x);
    pos_y <= POS_W'(y);
    layer <= LAYER_IN_W'(lay);
    color <= col;
    commands_sent++;
    if (kind == OP_CLEAR) clears_sent++;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_window(int w, int h, bit poke_spare);
    cfg_write <= 1'b1;
    cfg_index <= REG_WINDOW_WIDTH;
    cfg_data  <= WIN_W'(w);
    @(posedge clk);
    cfg_index <= REG_WINDOW_HEIGHT;
    cfg_data  <= WIN_W'(h);
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE_A;
      cfg_data  <= '0;
      @(posedge clk);
      cfg_index <= REG_SPARE_B;
      cfg_data  <= WIN_W'(1);
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    cur_w = (w > 256) ? 256 : w;
    cur_h = (h > 256) ? 256 : h;
  endtask

  // one step either side of the window boundary
  function automatic int edge_coord(int lim);
    int v;
    v = lim - 1 + int'($urandom_range(0, 1));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  function automatic int in_range(int lim);
    if (lim > 0) return int'($urandom_range(0, lim - 1));
    return int'($urandom_range(0, 3));
  endfunction

  function automatic int gap_len();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly revisits a small set of pixels so draws and reads meet
  task automatic random_command();
    int   r;
    int   m;
    int   slot;
    int   x;
    int   y;
    int   lay;
    op_t  kind;
    r    = $urandom_range(0, 99);
    m    = $urandom_range(0, 99);
    slot = $urandom_range(0, HOT_PIXELS - 1);
    if (r < 48) kind = OP_DRAW;
    else if (r < 92) kind = OP_READ;
    else if (r < 96) kind = OP_CLEAR;
    else kind = OP_NONE;
    if (m < 60) begin
      x = hot_x[slot];
      y = hot_y[slot];
    end else if (m < 70) begin
      x = edge_coord(cur_w);
      y = hot_y[slot];
    end else if (m < 80) begin
      x = hot_x[slot];
      y = edge_coord(cur_h);
    end else begin
      x = $urandom_range(0, 255);
      y = $urandom_range(0, 255);
    end
    lay = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 3) : $urandom_range(0, 255);
    issue(kind, x, y, lay, $urandom);
  endtask

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no command or result beat for %0d cycles", idle_cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset window, back to back so write-back forwarding is exercised
    issue(OP_READ,  0,   0,   0,   32'hDEAD_BEEF);
    issue(OP_DRAW,  0,   0,   200, 32'hFFFF_FFFF);
    issue(OP_READ,  0,   0,   0,   32'h0000_0000);
    issue(OP_DRAW,  0,   0,   201, 32'h1111_1111);
    issue(OP_DRAW,  0,   0,   200, 32'h1234_5678);
    issue(OP_READ,  0,   0,   255, 32'h0);
    issue(OP_DRAW,  0,   0,   0,   32'h0000_0000);
    issue(OP_READ,  0,   0,   0,   32'hFFFF_FFFF);
    issue(OP_DRAW,  255, 255, 255, 32'hA5A5_A5A5);
    issue(OP_DRAW,  255, 255, 255, 32'h5A5A_5A5A);
    issue(OP_READ,  255, 255, 0,   32'h0);
    issue(OP_DRAW,  255, 0,   128, 32'h8000_0001);
    issue(OP_DRAW,  0,   255, 127, 32'h7FFF_FFFE);
    issue(OP_NONE,  255, 255, 255, 32'hFFFF_FFFF);
    issue(OP_CLEAR, 255, 255, 255, 32'hFFFF_FFFF);
    issue(OP_READ,  0,   0,   0,   32'h0);
    issue(OP_READ,  255, 255, 0,   32'h0);
    issue(OP_DRAW,  0,   0,   255, 32'hCAFE_F00D);
    issue(OP_READ,  0,   0,   0,   32'h0);
    issue(OP_DRAW,  7,   9,   10,  32'h0BAD_CAFE);
    issue(OP_DRAW,  7,   9,   11,  32'h1357_9BDF);
    issue(OP_READ,  7,   9,   0,   32'h0);
    issue(OP_READ,  255, 0,   0,   32'h0);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_window(win_w_plan[p], win_h_plan[p], p == 3);
      for (int i = 0; i < HOT_PIXELS; i++) begin
        hot_x[i] = in_range(cur_w);
        hot_y[i] = in_range(cur_h);
      end
      for (int n = 0; n < item_plan[p]; n++) begin
        if (n % BURST_RUN == 0) burst = ($urandom_range(0, 9) < 3);
        random_command();
        pause(gap_len());
      end
      settle();
    end

    if (outstanding != 0) $error("%0d result beats never arrived", outstanding);
    $display("testbench: %0d commands (%0d clears) over %0d window settings, %0d beats checked",
             commands_sent, clears_sent, NUM_PHASES + 1, beats_checked);
    $display("testbench: %0d draws stored, %0d read hits, %0d mismatches",
             draws_stored, read_hits, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
